[hw/rtl/quaternion_vector_rotation_assert.svh]
// ----------------------------------------------------------------------------
// quaternion vector rotation assertion macros
// concurrent assertion shorthands clocked on clk_i, held off during reset
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATION_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATION_ASSERT_SVH

// same-cycle implication
`define QVR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QVR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/qvr_pkg.sv]
// ----------------------------------------------------------------------------
// qvr_pkg
// shared widths, types and helpers of the quaternion vector rotation block
// ----------------------------------------------------------------------------
package qvr_pkg;

  // number format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 30;

  // coefficient carries one more bit so a negated minimum code still fits
  localparam int COEF_W  = WORD_BITS + 1;
  // first round: vector times quaternion
  localparam int PROD_W  = WORD_BITS + COEF_W;
  localparam int TERM_W  = PROD_W + 2;
  // second round: term split into low word (unsigned) and high part (signed)
  localparam int HI_W    = TERM_W - WORD_BITS;
  localparam int LOP_W   = WORD_BITS + 1 + COEF_W;
  localparam int HIP_W   = HI_W + COEF_W;
  localparam int LOS_W   = LOP_W + 2;
  localparam int HIS_W   = HIP_W + 2;
  // full-precision result and the rounded integer part
  localparam int ACC_W   = HIS_W + WORD_BITS + 1;
  localparam int RES_W   = ACC_W - 2 * FRAC_BITS;

  // stream packing
  localparam int TDATA_W = ((3 * WORD_BITS + 7) / 8) * 8;

  // pipeline stages
  localparam int NSTG     = 6;
  localparam int ST_IN    = 0;
  localparam int ST_PROD1 = 1;
  localparam int ST_TSUM  = 2;
  localparam int ST_PROD2 = 3;
  localparam int ST_OSUM  = 4;
  localparam int ST_OUT   = 5;

  // register map
  localparam int REG_IDX_W = 2;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROT_X = 2'd0,
    REG_ROT_Y = 2'd1,
    REG_ROT_Z = 2'd2,
    REG_ROT_W = 2'd3
  } reg_idx_e;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [COEF_W-1:0]    coef_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [TERM_W-1:0]    term_t;
  typedef logic signed [LOP_W-1:0]     lop_t;
  typedef logic signed [HIP_W-1:0]     hip_t;
  typedef logic signed [LOS_W-1:0]     los_t;
  typedef logic signed [HIS_W-1:0]     his_t;
  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic [NSTG-1:0]             stage_en_t;

  localparam word_t WORD_MAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN   = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam acc_t  ROUND_HALF = ACC_W'(1) << (2 * FRAC_BITS - 1);
  localparam word_t W_RESET    = WORD_BITS'(1) << FRAC_BITS;

  // vector part of the quaternion held in both signs, so a mode bit only selects
  typedef struct packed {
    coef_t xp;
    coef_t xn;
    coef_t yp;
    coef_t yn;
    coef_t zp;
    coef_t zn;
    coef_t w;
  } quat_t;

  // product q * (v, 0)
  typedef struct packed {
    term_t ts;
    term_t t0;
    term_t t1;
    term_t t2;
  } tquat_t;

  // split sum of one output component
  typedef struct packed {
    his_t hi;
    los_t lo;
  } osum_t;

  typedef struct packed {
    osum_t z;
    osum_t y;
    osum_t x;
  } osum3_t;

  // coefficient for the current direction: inverse uses the conjugate
  function automatic coef_t sel_coef(logic inv, coef_t pos, coef_t neg);
    return inv ? neg : pos;
  endfunction

endpackage

[hw/rtl/quaternion_vector_rotation.sv]
// Rotates one signed fixed-point 3-vector per cycle, unless the output stalls,
// by the quaternion held in the rot_x/y/z/w registers: tuser 0 gives
// q*v*conj(q), tuser 1 the rotation by the conjugate. The quaternion is used
// as written, so a non-unit value also scales. Full-precision products are kept
// to the end, then each component is rounded to nearest (ties up) and
// saturated; tuser on the output flags any saturated component. Each item
// passes six register stages: the input register, a product and a sum register
// for each of the two multiply rounds, and the rounding output register. A
// stalled output lets the stages behind it fill up before tready drops.
// Write registers only while the block is empty.

// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// streaming quaternion rotation of 3-vectors, top level
// ----------------------------------------------------------------------------
module quaternion_vector_rotation import qvr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input items
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [TDATA_W-1:0]   s_tdata_i,   // vec_x, vec_y, vec_z
  input  logic                 s_tuser_i,   // mode
  // result items
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [TDATA_W-1:0]   m_tdata_o,   // out_x, out_y, out_z
  output logic                 m_tuser_o,   // clipped
  // register writes
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_BITS-1:0] cfg_wdata_i
);

  quat_t     quat;
  stage_en_t en;
  logic      mode_c;
  tquat_t    tq;
  osum3_t    osum;
  word_t     out_x, out_y, out_z;

  qvr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .quat_o      (quat)
  );

  qvr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .en_o       (en)
  );

  // q * (v, 0)
  qvr_lmul u_lmul (
    .clk_i   (clk_i),
    .en_i    (en),
    .quat_i  (quat),
    .mode_i  (s_tuser_i),
    .vec_x_i ($signed(s_tdata_i[WORD_BITS-1:0])),
    .vec_y_i ($signed(s_tdata_i[2*WORD_BITS-1:WORD_BITS])),
    .vec_z_i ($signed(s_tdata_i[3*WORD_BITS-1:2*WORD_BITS])),
    .mode_o  (mode_c),
    .t_o     (tq)
  );

  // times conj(q)
  qvr_rmul u_rmul (
    .clk_i  (clk_i),
    .en_i   (en),
    .quat_i (quat),
    .mode_i (mode_c),
    .t_i    (tq),
    .sum_o  (osum)
  );

  // round, saturate, output register
  qvr_fin u_fin (
    .clk_i     (clk_i),
    .en_i      (en),
    .sum_i     (osum),
    .out_x_o   (out_x),
    .out_y_o   (out_y),
    .out_z_o   (out_z),
    .clipped_o (m_tuser_o)
  );

  assign m_tdata_o = TDATA_W'({out_z, out_y, out_x});

endmodule

[hw/rtl/qvr_cfg.sv]
// ----------------------------------------------------------------------------
// qvr_cfg
// quaternion register bank, keeps each vector part in both signs
// ----------------------------------------------------------------------------
module qvr_cfg import qvr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_BITS-1:0] cfg_wdata_i,
  output quat_t                quat_o
);

  quat_t quat_q, quat_d;
  coef_t wr_pos;
  coef_t wr_neg;

  // decode a write
  always_comb begin
    wr_pos = COEF_W'($signed(cfg_wdata_i));
    wr_neg = -wr_pos;
    quat_d = quat_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ROT_X: begin
          quat_d.xp = wr_pos;
          quat_d.xn = wr_neg;
        end
        REG_ROT_Y: begin
          quat_d.yp = wr_pos;
          quat_d.yn = wr_neg;
        end
        REG_ROT_Z: begin
          quat_d.zp = wr_pos;
          quat_d.zn = wr_neg;
        end
        REG_ROT_W: begin
          quat_d.w = wr_pos;
        end
        default: begin
          quat_d = quat_q;
        end
      endcase
    end
  end

  // reset to the identity rotation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q <= '{w: COEF_W'(W_RESET), default: '0};
    end else begin
      quat_q <= quat_d;
    end
  end

  assign quat_o = quat_q;

endmodule

[hw/rtl/qvr_ctrl.sv]
// ----------------------------------------------------------------------------
// qvr_ctrl
// valid bits and per-stage load enables; bubbles close up on a stall
// ----------------------------------------------------------------------------
module qvr_ctrl import qvr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  output logic      m_tvalid_o,
  input  logic      m_tready_i,
  output stage_en_t en_o
);

  stage_en_t vld_q, vld_d;
  stage_en_t en;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || m_tready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    vld_d = vld_q;
    if (en[ST_IN]) begin
      vld_d[ST_IN] = s_tvalid_i;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en_o       = en;
  assign s_tready_o = en[ST_IN];
  assign m_tvalid_o = vld_q[ST_OUT];

endmodule

[hw/rtl/qvr_lmul.sv]
// ----------------------------------------------------------------------------
// qvr_lmul
// input register, then q * (v, 0): twelve products and four three-way sums
// ----------------------------------------------------------------------------
module qvr_lmul import qvr_pkg::*; (
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  quat_t     quat_i,
  input  logic      mode_i,
  input  word_t     vec_x_i,
  input  word_t     vec_y_i,
  input  word_t     vec_z_i,
  output logic      mode_o,
  output tquat_t    t_o
);

  // input stage
  logic  mode_a_q;
  word_t vx_a_q, vy_a_q, vz_a_q;
  // product stage
  logic  mode_b_q;
  prod_t p_q [12];
  prod_t p_d [12];
  // term stage
  logic   mode_c_q;
  tquat_t t_q, t_d;

  coef_t cx, cy, cz, ncx, ncy, ncz;

  always_ff @(posedge clk_i) begin
    if (en_i[ST_IN]) begin
      mode_a_q <= mode_i;
      vx_a_q   <= vec_x_i;
      vy_a_q   <= vec_y_i;
      vz_a_q   <= vec_z_i;
    end
  end

  // partial products of the quaternion-vector product
  always_comb begin
    cx  = sel_coef(mode_a_q, quat_i.xp, quat_i.xn);
    cy  = sel_coef(mode_a_q, quat_i.yp, quat_i.yn);
    cz  = sel_coef(mode_a_q, quat_i.zp, quat_i.zn);
    ncx = sel_coef(mode_a_q, quat_i.xn, quat_i.xp);
    ncy = sel_coef(mode_a_q, quat_i.yn, quat_i.yp);
    ncz = sel_coef(mode_a_q, quat_i.zn, quat_i.zp);
    // scalar part
    p_d[0]  = vx_a_q * ncx;
    p_d[1]  = vy_a_q * ncy;
    p_d[2]  = vz_a_q * ncz;
    // x part
    p_d[3]  = vx_a_q * quat_i.w;
    p_d[4]  = vz_a_q * cy;
    p_d[5]  = vy_a_q * ncz;
    // y part
    p_d[6]  = vy_a_q * quat_i.w;
    p_d[7]  = vz_a_q * ncx;
    p_d[8]  = vx_a_q * cz;
    // z part
    p_d[9]  = vz_a_q * quat_i.w;
    p_d[10] = vy_a_q * cx;
    p_d[11] = vx_a_q * ncy;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_PROD1]) begin
      mode_b_q <= mode_a_q;
      p_q      <= p_d;
    end
  end

  // sum the products into the four quaternion parts
  always_comb begin
    t_d.ts = TERM_W'(p_q[0]) + TERM_W'(p_q[1])  + TERM_W'(p_q[2]);
    t_d.t0 = TERM_W'(p_q[3]) + TERM_W'(p_q[4])  + TERM_W'(p_q[5]);
    t_d.t1 = TERM_W'(p_q[6]) + TERM_W'(p_q[7])  + TERM_W'(p_q[8]);
    t_d.t2 = TERM_W'(p_q[9]) + TERM_W'(p_q[10]) + TERM_W'(p_q[11]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_TSUM]) begin
      mode_c_q <= mode_b_q;
      t_q      <= t_d;
    end
  end

  assign mode_o = mode_c_q;
  assign t_o    = t_q;

endmodule

[hw/rtl/qvr_rmul.sv]
// ----------------------------------------------------------------------------
// qvr_rmul
// vector part of t * conj(q); each wide term is multiplied as a low word and
// a high part, and the two halves are summed apart
// ----------------------------------------------------------------------------
module qvr_rmul import qvr_pkg::*; (
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  quat_t     quat_i,
  input  logic      mode_i,
  input  tquat_t    t_i,
  output osum3_t    sum_o
);

  lop_t   lo_q [3][4];
  lop_t   lo_d [3][4];
  hip_t   hi_q [3][4];
  hip_t   hi_d [3][4];
  osum3_t sum_q, sum_d;

  coef_t cx, cy, cz, ncx, ncy, ncz;
  coef_t cf [3][4];
  term_t tv [4];

  // coefficient grid and split products
  always_comb begin
    cx  = sel_coef(mode_i, quat_i.xp, quat_i.xn);
    cy  = sel_coef(mode_i, quat_i.yp, quat_i.yn);
    cz  = sel_coef(mode_i, quat_i.zp, quat_i.zn);
    ncx = sel_coef(mode_i, quat_i.xn, quat_i.xp);
    ncy = sel_coef(mode_i, quat_i.yn, quat_i.yp);
    ncz = sel_coef(mode_i, quat_i.zn, quat_i.zp);
    tv[0] = t_i.ts;
    tv[1] = t_i.t0;
    tv[2] = t_i.t1;
    tv[3] = t_i.t2;
    cf[0][0] = ncx;  cf[0][1] = quat_i.w; cf[0][2] = ncz;      cf[0][3] = cy;
    cf[1][0] = ncy;  cf[1][1] = cz;       cf[1][2] = quat_i.w; cf[1][3] = ncx;
    cf[2][0] = ncz;  cf[2][1] = ncy;      cf[2][2] = cx;       cf[2][3] = quat_i.w;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        lo_d[i][j] = $signed({1'b0, tv[j][WORD_BITS-1:0]}) * cf[i][j];
        hi_d[i][j] = $signed(tv[j][TERM_W-1:WORD_BITS]) * cf[i][j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_PROD2]) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // add the four terms of each component, low and high halves apart
  always_comb begin
    sum_d.x.lo = LOS_W'(lo_q[0][0]) + LOS_W'(lo_q[0][1])
               + LOS_W'(lo_q[0][2]) + LOS_W'(lo_q[0][3]);
    sum_d.x.hi = HIS_W'(hi_q[0][0]) + HIS_W'(hi_q[0][1])
               + HIS_W'(hi_q[0][2]) + HIS_W'(hi_q[0][3]);
    sum_d.y.lo = LOS_W'(lo_q[1][0]) + LOS_W'(lo_q[1][1])
               + LOS_W'(lo_q[1][2]) + LOS_W'(lo_q[1][3]);
    sum_d.y.hi = HIS_W'(hi_q[1][0]) + HIS_W'(hi_q[1][1])
               + HIS_W'(hi_q[1][2]) + HIS_W'(hi_q[1][3]);
    sum_d.z.lo = LOS_W'(lo_q[2][0]) + LOS_W'(lo_q[2][1])
               + LOS_W'(lo_q[2][2]) + LOS_W'(lo_q[2][3]);
    sum_d.z.hi = HIS_W'(hi_q[2][0]) + HIS_W'(hi_q[2][1])
               + HIS_W'(hi_q[2][2]) + HIS_W'(hi_q[2][3]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_OSUM]) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

[hw/rtl/qvr_fin.sv]
// ----------------------------------------------------------------------------
// qvr_fin
// joins the split sums, rounds to nearest, saturates, and holds the result
// ----------------------------------------------------------------------------
module qvr_fin import qvr_pkg::*; (
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  osum3_t    sum_i,
  output word_t     out_x_o,
  output word_t     out_y_o,
  output word_t     out_z_o,
  output logic      clipped_o
);

  word_t ox_q, oy_q, oz_q;
  logic  clip_q;
  logic [WORD_BITS:0] fx, fy, fz;

  // returns {saturated, code}
  function automatic logic [WORD_BITS:0] finish(osum_t s);
    acc_t                    acc;
    logic signed [RES_W-1:0] res;
    logic                    fits;
    acc  = (ACC_W'(s.hi) <<< WORD_BITS) + ACC_W'(s.lo) + ROUND_HALF;
    res  = acc[ACC_W-1:2*FRAC_BITS];
    fits = (&res[RES_W-1:WORD_BITS-1]) || !(|res[RES_W-1:WORD_BITS-1]);
    if (fits) begin
      return {1'b0, res[WORD_BITS-1:0]};
    end
    return {1'b1, (res[RES_W-1] ? WORD_MIN : WORD_MAX)};
  endfunction

  always_comb begin
    fx = finish(sum_i.x);
    fy = finish(sum_i.y);
    fz = finish(sum_i.z);
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en_i[ST_OUT]) begin
      ox_q   <= fx[WORD_BITS-1:0];
      oy_q   <= fy[WORD_BITS-1:0];
      oz_q   <= fz[WORD_BITS-1:0];
      clip_q <= fx[WORD_BITS] | fy[WORD_BITS] | fz[WORD_BITS];
    end
  end

  assign out_x_o   = ox_q;
  assign out_y_o   = oy_q;
  assign out_z_o   = oz_q;
  assign clipped_o = clip_q;

endmodule

[hw/rtl/qvr_chk.sv]
// ----------------------------------------------------------------------------
// qvr_chk
// port-level checks of the rotation block, bound to the top level
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotation_assert.svh"

module qvr_chk import qvr_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_tready_o,
  input logic                 m_tvalid_o,
  input logic                 m_tready_i,
  input logic [TDATA_W-1:0]   m_tdata_o,
  input logic                 m_tuser_o
);

  word_t ox, oy, oz;
  logic  out_stall;
  logic  out_extreme;

  assign ox = m_tdata_o[WORD_BITS-1:0];
  assign oy = m_tdata_o[2*WORD_BITS-1:WORD_BITS];
  assign oz = m_tdata_o[3*WORD_BITS-1:2*WORD_BITS];

  assign out_stall   = m_tvalid_o && !m_tready_i;
  assign out_extreme = ox == WORD_MAX || ox == WORD_MIN || oy == WORD_MAX ||
                       oy == WORD_MIN || oz == WORD_MAX || oz == WORD_MIN;

  // a result waiting is not withdrawn
  `QVR_ASSERT_NEXT(a_out_valid_hold, out_stall, m_tvalid_o, "result dropped while stalled")

  // a waiting result does not change
  `QVR_ASSERT_NEXT(a_out_data_hold, out_stall, $stable({m_tuser_o, m_tdata_o}), "result changed")

  // input is held back only when the whole pipe is full behind a stalled output
  `QVR_ASSERT_IMP(a_ready_full, !s_tready_o, out_stall, "input stalled with room in pipe")

  // a saturation flag comes with at least one extreme code
  `QVR_ASSERT_IMP(a_clip_code, m_tvalid_o && m_tuser_o, out_extreme, "clip without extreme code")

endmodule

bind quaternion_vector_rotation qvr_chk u_chk (.*);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// quaternion vector rotation testbench
// self-checking stream test: vectors go in phases, each phase under one
// quaternion setting; every result is predicted at input accept from an
// exact wide-integer model and compared field by field at output accept
// ----------------------------------------------------------------------------
module testbench;
  import qvr_pkg::*;

  // run shape
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 200;
  localparam int DRAIN_PAD   = 12;
  localparam int HOLD_AT     = 620;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SHOW_ERRS   = 10;

  // exact arithmetic width, results stay well below it
  typedef logic signed [159:0] wide_t;

  localparam wide_t SAT_HI   = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
  localparam wide_t SAT_LO   = -(wide_t'(1) <<< (WORD_BITS - 1));
  localparam wide_t HALF_LSB = wide_t'(1) <<< (2 * FRAC_BITS - 1);
  localparam word_t SIN45    = 32'sd759250125;

  typedef struct packed {
    logic  inv;
    word_t vx;
    word_t vy;
    word_t vz;
  } vec_item_t;

  typedef struct packed {
    word_t ox;
    word_t oy;
    word_t oz;
    logic  clip;
  } rot_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_tvalid_i = 1'b0;
  logic                 s_tready_o;
  logic [TDATA_W-1:0]   s_tdata_i  = '0;
  logic                 s_tuser_i  = 1'b0;
  logic                 m_tvalid_o;
  logic                 m_tready_i = 1'b0;
  logic [TDATA_W-1:0]   m_tdata_o;
  logic                 m_tuser_o;
  logic                 cfg_we_i   = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i  = REG_ROT_X;
  logic [WORD_BITS-1:0] cfg_wdata_i = '0;

  // quaternion as the block should hold it, indexed by register
  word_t       quat_regs [4];
  vec_item_t   vec_pending_q [$];
  rot_result_t expected_q [$];

  int accepted_in  = 0;
  int accepted_out = 0;
  int inv_count    = 0;
  int clip_count   = 0;
  int err_count    = 0;
  int idle_cycles  = 0;
  int settings_run = 1;

  quaternion_vector_rotation dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),    // vec_x, vec_y, vec_z
    .s_tuser_i  (s_tuser_i),    // mode
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),    // out_x, out_y, out_z
    .m_tuser_o  (m_tuser_o),    // clipped
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // round half up at 2*FRAC_BITS, then clamp to the word range
  function automatic word_t round_to_word(input wide_t acc, inout logic clip);
    wide_t r;
    r = (acc + HALF_LSB) >>> (2 * FRAC_BITS);
    if (r > SAT_HI) begin
      clip = 1'b1;
      return WORD_MAX;
    end
    if (r < SAT_LO) begin
      clip = 1'b1;
      return WORD_MIN;
    end
    return word_t'(r);
  endfunction

  // q*v*conj(q), or conj(q)*v*q for the inverse direction
  function automatic rot_result_t rotate_vector(input vec_item_t it);
    wide_t qx, qy, qz, qw, ax, ay, az;
    wide_t ts, t0, t1, t2, o0, o1, o2;
    rot_result_t res;
    logic clip;
    qx = quat_regs[REG_ROT_X];
    qy = quat_regs[REG_ROT_Y];
    qz = quat_regs[REG_ROT_Z];
    qw = quat_regs[REG_ROT_W];
    if (it.inv) begin
      qx = -qx;
      qy = -qy;
      qz = -qz;
    end
    ax = it.vx;
    ay = it.vy;
    az = it.vz;
    // q * (v, 0)
    ts = -qx * ax - qy * ay - qz * az;
    t0 = qw * ax + qy * az - qz * ay;
    t1 = qw * ay - qx * az + qz * ax;
    t2 = qw * az + qx * ay - qy * ax;
    // vector part of t * conj(q)
    o0 = -qx * ts + qw * t0 - qz * t1 + qy * t2;
    o1 = -qy * ts + qz * t0 + qw * t1 - qx * t2;
    o2 = -qz * ts - qy * t0 + qx * t1 + qw * t2;
    clip = 1'b0;
    res.ox = round_to_word(o0, clip);
    res.oy = round_to_word(o1, clip);
    res.oz = round_to_word(o2, clip);
    res.clip = clip;
    return res;
  endfunction

  // random word: full range, moderate magnitude, or a corner value
  function automatic word_t pick_word(input int kind);
    case (kind)
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
      default: begin
        case ($urandom_range(0, 5))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return '0;
          3: return -32'sd1;
          4: return 32'sd1;
          default: return W_RESET;
        endcase
      end
    endcase
  endfunction

  task automatic add_vec(input logic inv, input word_t vx, input word_t vy, input word_t vz);
    vec_item_t it;
    it.inv = inv;
    it.vx = vx;
    it.vy = vy;
    it.vz = vz;
    vec_pending_q.push_back(it);
  endtask

  // one register write, mirrored into the local quaternion copy
  task automatic write_reg(input reg_idx_e idx, input word_t val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    quat_regs[idx] = val;
  endtask

  task automatic write_quat(input word_t qx, input word_t qy, input word_t qz,
                            input word_t qw);
    write_reg(REG_ROT_X, qx);
    write_reg(REG_ROT_Y, qy);
    write_reg(REG_ROT_Z, qz);
    write_reg(REG_ROT_W, qw);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  // wait until everything sent has come back and the pipe is empty
  task automatic drain();
    do @(negedge clk_i);
    while (vec_pending_q.size() != 0 || s_tvalid_i || expected_q.size() != 0);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  // driver: bursts of items with random gaps between them
  int        burst_left;
  int        gap_left;
  vec_item_t drv_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!s_tvalid_i || s_tready_o) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_tvalid_i <= 1'b0;
      end else if (vec_pending_q.size() != 0) begin
        drv_item = vec_pending_q.pop_front();
        s_tvalid_i <= 1'b1;
        s_tdata_i <= {drv_item.vz, drv_item.vy, drv_item.vx};
        s_tuser_i <= drv_item.inv;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes every so often, one long hold-off
  int   ready_style;
  int   style_left;
  int   hold_left;
  logic hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
      ready_style <= 0;
      style_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_in >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready_i <= 1'b0;
    end else begin
      if (style_left == 0) begin
        ready_style <= $urandom_range(0, 3);
        style_left <= $urandom_range(16, 160);
      end else begin
        style_left <= style_left - 1;
      end
      case (ready_style)
        0: m_tready_i <= 1'b1;
        1: m_tready_i <= 1'($urandom_range(0, 1));
        2: m_tready_i <= ($urandom_range(0, 7) != 0);
        default: m_tready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // monitor: check results, predict at input accept, watchdog
  rot_result_t want;
  rot_result_t got;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // result side
      if (m_tvalid_o && m_tready_i) begin
        accepted_out <= accepted_out + 1;
        got.ox = m_tdata_o[WORD_BITS-1:0];
        got.oy = m_tdata_o[2*WORD_BITS-1:WORD_BITS];
        got.oz = m_tdata_o[3*WORD_BITS-1:2*WORD_BITS];
        got.clip = m_tuser_o;
        if (got.clip) clip_count <= clip_count + 1;
        if (expected_q.size() == 0) begin
          if (err_count < SHOW_ERRS)
            $display("unexpected result x=%h y=%h z=%h clip=%b",
                     got.ox, got.oy, got.oz, got.clip);
          err_count <= err_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.ox !== want.ox || got.oy !== want.oy || got.oz !== want.oz ||
              got.clip !== want.clip) begin
            if (err_count < SHOW_ERRS) begin
              $display("result %0d mismatch: exp x=%h y=%h z=%h clip=%b",
                       accepted_out, want.ox, want.oy, want.oz, want.clip);
              $display("  got x=%h y=%h z=%h clip=%b",
                       got.ox, got.oy, got.oz, got.clip);
            end
            err_count <= err_count + 1;
          end
        end
      end
      // input side
      if (s_tvalid_i && s_tready_o) begin
        accepted_in <= accepted_in + 1;
        if (s_tuser_i) inv_count <= inv_count + 1;
        expected_q.push_back(rotate_vector({s_tuser_i,
                                            s_tdata_i[WORD_BITS-1:0],
                                            s_tdata_i[2*WORD_BITS-1:WORD_BITS],
                                            s_tdata_i[3*WORD_BITS-1:2*WORD_BITS]}));
      end
      // stuck run
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("quaternion_vector_rotation regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus phases
  initial begin
    int kind;
    int vkind;
    quat_regs[REG_ROT_X] = '0;
    quat_regs[REG_ROT_Y] = '0;
    quat_regs[REG_ROT_Z] = '0;
    quat_regs[REG_ROT_W] = W_RESET;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // identity after reset, corner vectors both directions
    add_vec(1'b0, '0, '0, '0);
    add_vec(1'b0, WORD_MAX, WORD_MIN, 32'sd1);
    add_vec(1'b1, WORD_MIN, WORD_MIN, WORD_MIN);
    add_vec(1'b1, WORD_MAX, WORD_MAX, WORD_MAX);
    add_vec(1'b0, -32'sd1, 32'sd1, 32'sh1234_5678);
    drain();

    // tiny scalar part leaves exact halves: ties must round upward
    write_quat('0, '0, '0, 32'sh0000_8000);
    @(negedge clk_i);
    add_vec(1'b0, 32'sh2000_0000, -32'sh2000_0000, 32'sh6000_0000);
    add_vec(1'b1, -32'sh6000_0000, 32'sh2000_0000, -32'sd1);
    drain();

    // quarter turn about z
    write_quat('0, '0, SIN45, SIN45);
    @(negedge clk_i);
    add_vec(1'b0, W_RESET, '0, '0);
    add_vec(1'b1, W_RESET, '0, '0);
    add_vec(1'b0, '0, W_RESET, '0);
    add_vec(1'b1, WORD_MAX, WORD_MIN, '0);
    drain();

    // non-unit extremes, heavy saturation
    write_quat(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    @(negedge clk_i);
    add_vec(1'b0, WORD_MAX, WORD_MIN, -32'sd1);
    add_vec(1'b1, WORD_MAX, WORD_MIN, -32'sd1);
    add_vec(1'b0, 32'sd1, 32'sd1, 32'sd1);
    drain();

    write_quat(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    @(negedge clk_i);
    add_vec(1'b0, WORD_MIN, WORD_MAX, WORD_MIN);
    add_vec(1'b1, 32'sd1, '0, '0);
    add_vec(1'b0, '0, '0, '0);
    drain();

    // random phases, each under a fresh quaternion
    for (int p = 0; p < RAND_PHASES; p++) begin
      kind = (p % 3 == 0) ? 1 : $urandom_range(0, 2);
      write_quat(pick_word(kind), pick_word(kind), pick_word(kind), pick_word(kind));
      @(negedge clk_i);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        vkind = $urandom_range(0, 9);
        vkind = (vkind < 5) ? 0 : (vkind < 9) ? 1 : 2;
        add_vec(1'($urandom_range(0, 1)),
                pick_word(vkind), pick_word(vkind), pick_word(vkind));
      end
      drain();
    end

    $display("rotated %0d vectors (%0d inverse) under %0d quaternion settings",
             accepted_in, inv_count, settings_run);
    $display("%0d results saturated, %0d mismatches", clip_count, err_count);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("quaternion_vector_rotation regression: pass");
    end else begin
      $display("quaternion_vector_rotation regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/qvr_pkg.sv
hw/rtl/qvr_cfg.sv
hw/rtl/qvr_ctrl.sv
hw/rtl/qvr_lmul.sv
hw/rtl/qvr_rmul.sv
hw/rtl/qvr_fin.sv
hw/rtl/quaternion_vector_rotation.sv
hw/rtl/qvr_chk.sv
dv/testbench.sv
